/* hw/rtl/modbus_tcp_rtu_frame_converter_unit_macros.svh */
// Assertion macros shared by the converter's checker.
`ifndef MODBUS_TCP_RTU_FRAME_CONVERTER_UNIT_MACROS_SVH
`define MODBUS_TCP_RTU_FRAME_CONVERTER_UNIT_MACROS_SVH

// Checked only outside reset.
`define MTRC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtrc assertion failed");

// Checked at every edge, reset included.
`define MTRC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mtrc assertion failed");

`endif

/* hw/rtl/mtrc_pkg.sv */
// Shared types, constants and the CRC helper of the frame converter.
package mtrc_pkg;

  localparam int HeaderBytes   = 6;
  localparam int MaxFrameBytes = 260;
  localparam int MaxResults    = 6;
  localparam int PosW          = 9;
  localparam int HdrIdxW       = 3;
  localparam int CntW          = 3;

  localparam logic [1:0] ModeReq = 2'd0;
  localparam logic [1:0] ModeRsp = 2'd1;
  localparam logic [1:0] ModeTmo = 2'd2;

  localparam logic       RegTimeoutLimit = 1'b0;
  localparam logic [7:0] TimeoutLimitRst = 8'd50;
  localparam logic [15:0] CrcInit        = 16'hFFFF;
  localparam logic [15:0] CrcPoly        = 16'hA001;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       reboot;
  } res_t;

  typedef struct packed {
    res_t [MaxResults-1:0] ent;
    logic [CntW-1:0]       cnt;
  } rlist_t;

  // Modbus CRC-16, one byte folded in, LSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/mtrc_core.sv */
// Frame state (position, CRC, delay line, header, timeout count) and result list.
module mtrc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [7:0]          limit_i,
  output mtrc_pkg::rlist_t    list_o
);

  logic [mtrc_pkg::PosW-1:0] pos_q, pos_d;
  logic [15:0]               crc_q, crc_d;
  logic [7:0]                dly0_q, dly0_d, dly1_q, dly1_d;
  logic [7:0]                tocnt_q, tocnt_d;
  logic [7:0]                hdr_q [mtrc_pkg::HeaderBytes];
  logic                      hdr_we;
  logic                      in_range, in_hdr, fwd;
  logic [15:0]               crc_new;
  mtrc_pkg::rlist_t          list;

  assign in_range = pos_q < mtrc_pkg::PosW'(mtrc_pkg::MaxFrameBytes);
  assign in_hdr   = pos_q < mtrc_pkg::PosW'(mtrc_pkg::HeaderBytes);
  assign fwd      = in_range && !in_hdr;
  assign crc_new  = fwd ? mtrc_pkg::crc_fold(crc_q, byte_i) : crc_q;

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    dly0_d  = dly0_q;
    dly1_d  = dly1_q;
    tocnt_d = tocnt_q;
    hdr_we  = 1'b0;
    list    = '0;
    case (mode_i)
      mtrc_pkg::ModeReq: begin
        if (in_range) begin
          hdr_we = in_hdr;
          crc_d  = crc_new;
          pos_d  = pos_q + mtrc_pkg::PosW'(1);
        end
        if (fwd) begin
          list.ent[0] = '{valid: 1'b1, data: byte_i, reboot: 1'b0};
          if (last_i) begin
            list.ent[1] = '{valid: 1'b1, data: crc_new[7:0], reboot: 1'b0};
            list.ent[2] = '{valid: 1'b1, data: crc_new[15:8], reboot: 1'b0};
            list.cnt    = mtrc_pkg::CntW'(3);
          end else begin
            list.cnt    = mtrc_pkg::CntW'(1);
          end
        end else if (last_i) begin
          list.ent[0] = '{valid: 1'b1, data: crc_new[7:0], reboot: 1'b0};
          list.ent[1] = '{valid: 1'b1, data: crc_new[15:8], reboot: 1'b0};
          list.cnt    = mtrc_pkg::CntW'(2);
        end
        if (last_i) begin
          pos_d = '0;
          crc_d = mtrc_pkg::CrcInit;
        end
      end
      mtrc_pkg::ModeRsp: begin
        tocnt_d = '0;
        if (in_range) begin
          if (pos_q == '0) begin
            // first byte of a response brings out the stored header
            for (int k = 0; k < mtrc_pkg::HeaderBytes; k++) begin
              list.ent[k] = '{valid: 1'b1, data: hdr_q[k], reboot: 1'b0};
            end
            list.cnt = mtrc_pkg::CntW'(mtrc_pkg::HeaderBytes);
          end else if (pos_q >= mtrc_pkg::PosW'(2)) begin
            list.ent[0] = '{valid: 1'b1, data: dly0_q, reboot: 1'b0};
            list.cnt    = mtrc_pkg::CntW'(1);
          end
          dly0_d = dly1_q;
          dly1_d = byte_i;
          pos_d  = pos_q + mtrc_pkg::PosW'(1);
        end
        if (last_i) begin
          pos_d  = '0;
          dly0_d = '0;
          dly1_d = '0;
        end
      end
      mtrc_pkg::ModeTmo: begin
        if (tocnt_q != 8'hFF) begin
          tocnt_d = tocnt_q + 8'd1;
        end
        pos_d       = '0;
        crc_d       = mtrc_pkg::CrcInit;
        dly0_d      = '0;
        dly1_d      = '0;
        list.ent[0] = '{valid: 1'b0, data: 8'h00, reboot: (tocnt_q > limit_i)};
        list.cnt    = mtrc_pkg::CntW'(1);
      end
      default: begin
        list = '0;
      end
    endcase
  end

  assign list_o = list;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= mtrc_pkg::CrcInit;
      dly0_q  <= '0;
      dly1_q  <= '0;
      tocnt_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      dly0_q  <= dly0_d;
      dly1_q  <= dly1_d;
      tocnt_q <= tocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && hdr_we) begin
      hdr_q[pos_q[mtrc_pkg::HdrIdxW-1:0]] <= byte_i;
    end
  end

endmodule

/* hw/rtl/mtrc_out_queue.sv */
// Result register: holds one item's result list and hands it out one result a cycle while m_axis_tready_i is high.
module mtrc_out_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mtrc_pkg::rlist_t list_i,
  output logic             ready_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,
  output logic [1:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  mtrc_pkg::res_t [mtrc_pkg::MaxResults-1:0] ent_q, ent_shift;
  logic [mtrc_pkg::CntW-1:0]                 cnt_q;
  logic                                      pop;

  assign pop     = m_axis_tvalid_o && m_axis_tready_i;
  assign ready_o = (cnt_q == '0) || ((cnt_q == mtrc_pkg::CntW'(1)) && m_axis_tready_i);

  always_comb begin
    for (int i = 0; i < mtrc_pkg::MaxResults - 1; i++) begin
      ent_shift[i] = ent_q[i+1];
    end
    ent_shift[mtrc_pkg::MaxResults-1] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= list_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - mtrc_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= list_i.ent;
    end else if (pop) begin
      ent_q <= ent_shift;
    end
  end

  assign m_axis_tvalid_o = cnt_q != '0;
  assign m_axis_tdata_o  = ent_q[0].data;
  assign m_axis_tuser_o  = {ent_q[0].reboot, ent_q[0].valid};
  assign m_axis_tlast_o  = cnt_q == mtrc_pkg::CntW'(1);

endmodule

/* hw/rtl/modbus_tcp_rtu_frame_converter_unit.sv */
// Top level of the Modbus TCP to RTU frame converter.
//
//   channel   direction  payload
//   s_axis    in         tdata in_byte, tuser mode, tlast in_last
//   m_axis    out        tdata out_byte, tuser out_valid/reboot_request, tlast out_last
//   apb       in         register 0 timeout_limit at byte address 0
//
// An item is taken when s_axis_tvalid_i and s_axis_tready_o are both high; its
// results are loaded into the result register and leave it one per cycle while
// m_axis_tready_i is high: one for a forwarded byte or a timeout, none for a
// header byte or an ignored item, 2 or 3 for the last byte of a request (CRC
// appended), up to 6 for the first byte of a response (header replay).
// s_axis_tready_o is high while the result register is empty or its final
// result is being taken, so single-result items flow back to back. Reset clears
// frame state, timeout count and result register; header bytes are not reset.
module modbus_tcp_rtu_frame_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser_o,   // [0] out_valid, [1] reboot_request
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             accept;
  logic             q_ready;
  logic [7:0]       limit_q;
  mtrc_pkg::rlist_t list;

  assign pready          = 1'b1;
  assign s_axis_tready_o = q_ready;
  assign accept          = s_axis_tvalid_i && q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= mtrc_pkg::TimeoutLimitRst;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == mtrc_pkg::RegTimeoutLimit)) begin
      limit_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == mtrc_pkg::RegTimeoutLimit) ? {24'h000000, limit_q} : 32'h0;

  mtrc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (s_axis_tuser_i),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .limit_i  (limit_q),
    .list_o   (list)
  );

  mtrc_out_queue u_queue (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (accept),
    .list_i          (list),
    .ready_o         (q_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

/* hw/rtl/mtrc_checker.sv */
// Port-level checks on the frame converter, bound to the top level.
`include "modbus_tcp_rtu_frame_converter_unit_macros.svh"

module mtrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // stalled result holds
  `MTRC_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))

  // no new item while results of the previous one are still pending
  `MTRC_ASSERT(a_no_overrun, clk_i, rst_ni,
    m_axis_tvalid_o && !(m_axis_tready_i && m_axis_tlast_o) |-> !s_axis_tready_o)

  // a status result stands alone, carries no byte
  `MTRC_ASSERT(a_status_form, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tlast_o && (m_axis_tdata_o == 8'h00))

  // reboot only flagged on a status result
  `MTRC_ASSERT(a_reboot_status, clk_i, rst_ni,
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> !m_axis_tuser_o[0])

  `MTRC_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !m_axis_tvalid_o)

endmodule

bind modbus_tcp_rtu_frame_converter_unit mtrc_checker u_mtrc_checker (.*);
